// File: sv/rdsm_pkg.sv
// Shared types, constants and helpers for the dot-star pattern matcher.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package rdsm_pkg;

  localparam int DEF_MAX_PATTERN = 16;

  localparam int CMD_W    = 2;
  localparam int INDEX_W  = 4;
  localparam int BYTE_W   = 8;
  localparam int LENGTH_W = 5;

  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_BEGIN = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TEXT  = 2'd2;

  localparam logic [BYTE_W-1:0] STAR_BYTE = 8'h2A;
  localparam logic [BYTE_W-1:0] DOT_BYTE  = 8'h2E;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } rdsm_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;    // latch the request kind and text byte, clear the cell counter
    logic pat_write;  // write the pattern byte into the store
    logic step;       // evaluate one cell of the match row
    logic out_load;   // move the final match bit into the output register
  } rdsm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_cell;
  } rdsm_status_t;

  function automatic logic elem_match(input logic [BYTE_W-1:0] pc,
                                      input logic [BYTE_W-1:0] c);
    return (pc == DOT_BYTE) || (pc == c);
  endfunction

endpackage

`default_nettype wire

// File: sv/rdsm_ctrl.sv
// Controller of the dot-star matcher: handshakes and cell sequencing.
// Depends on rdsm_pkg; drives rdsm_datapath through rdsm_cmd_t.
`default_nettype none

module rdsm_ctrl
  import rdsm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [CMD_W-1:0] cmd,
  output logic             out_valid,
  input  logic             out_ready,
  output rdsm_cmd_t        dp_cmd,
  input  rdsm_status_t     dp_status
);

  rdsm_state_t state, state_next;
  logic        out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    dp_cmd     = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          dp_cmd.capture   = 1'b1;
          dp_cmd.pat_write = (cmd == CMD_WRITE);
          if (cmd == CMD_BEGIN || cmd == CMD_TEXT) begin
            state_next = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        dp_cmd.step = 1'b1;
        if (dp_status.last_cell) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // The previous result must be gone before this one takes its place.
        if (!out_valid || out_ready) begin
          dp_cmd.out_load = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase

    if (dp_cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

`default_nettype wire

// File: sv/rdsm_datapath.sv
// Datapath of the dot-star matcher: pattern store, match row, result register.
// Depends on rdsm_pkg; sequenced by rdsm_ctrl.
`default_nettype none

module rdsm_datapath
  import rdsm_pkg::*;
#(
  parameter int MAX_PATTERN = DEF_MAX_PATTERN
)(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [LENGTH_W-1:0] cfg_wdata,
  input  logic [CMD_W-1:0]    cmd,
  input  logic [INDEX_W-1:0]  pattern_index,
  input  logic [BYTE_W-1:0]   byte_value,
  output logic                matched,
  input  rdsm_cmd_t           dp_cmd,
  output rdsm_status_t        dp_status
);

  localparam int CW = $clog2(MAX_PATTERN + 1);
  localparam int AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int LW = (CW > LENGTH_W) ? CW : LENGTH_W;

  logic [BYTE_W-1:0]   pstore [MAX_PATTERN];
  logic [BYTE_W-1:0]   rd_data;
  logic [BYTE_W-1:0]   pe;
  logic [BYTE_W-1:0]   text;
  logic                is_begin;
  logic [CW-1:0]       cell_idx;
  logic [MAX_PATTERN:0] row;
  logic                old_prev;
  logic                n1;
  logic                n2;
  logic                res;
  logic [LENGTH_W-1:0] pattern_length;

  logic [LW-1:0]       len_ext;
  logic [CW-1:0]       used_len;
  logic                head;
  logic                ge2;
  logic                nv;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= '0;
    end else if (cfg_we) begin
      pattern_length <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.pat_write && int'(pattern_index) < MAX_PATTERN) begin
      pstore[AW'(pattern_index)] <= byte_value;
    end
    if (dp_cmd.step && cell_idx < CW'(MAX_PATTERN)) begin
      rd_data <= pstore[cell_idx[AW-1:0]];
    end
  end

  always_comb begin
    len_ext  = LW'(pattern_length);
    used_len = (len_ext > LW'(MAX_PATTERN)) ? CW'(MAX_PATTERN) : CW'(len_ext);
  end

  // One cell per step: row[0] always holds the old value of the current cell,
  // while new values enter at the top, so the row is rebuilt in place.
  always_comb begin
    head = row[0];
    ge2  = (cell_idx > CW'(1));
    if (cell_idx == '0) begin
      nv = is_begin;
    end else if (rd_data == STAR_BYTE) begin
      nv = ge2 && (n2 || (!is_begin && elem_match(pe, text) && head));
    end else begin
      nv = !is_begin && elem_match(rd_data, text) && old_prev;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
    end else if (dp_cmd.step) begin
      row <= {nv, row[MAX_PATTERN:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.capture) begin
      is_begin <= (cmd == CMD_BEGIN);
      text     <= byte_value;
      cell_idx <= '0;
    end else if (dp_cmd.step) begin
      cell_idx <= cell_idx + CW'(1);
      old_prev <= head;
      n1       <= nv;
      n2       <= n1;
      pe       <= rd_data;
      if (cell_idx == used_len) begin
        res <= nv;
      end
    end
    if (dp_cmd.out_load) begin
      matched <= res;
    end
  end

  assign dp_status.last_cell = (cell_idx == CW'(MAX_PATTERN));

endmodule

`default_nettype wire

// File: sv/regex_dot_star_matcher.sv
// Whole-text matcher for patterns of literal bytes, '.' and '*'.
// Input channel (in_valid/in_ready): cmd, pattern_index, byte_value.
//   A write request stores one pattern byte and gives no result. A begin
//   request builds the empty-text row, a text request advances the row
//   by one byte; each gives one result on the output.
// Output channel (out_valid/out_ready): matched, 1 when the text so far
//   matches the whole pattern of min(pattern_length, MAX_PATTERN) bytes.
// cfg_we/cfg_wdata set pattern_length; write it only while the block idles.
// Sequencing: a begin or text request walks the row one cell per cycle,
//   from cell 0 to cell MAX_PATTERN; the cell sequencer and the single
//   read port of the pattern store set this pace.
// Throughput: after a begin or text request the block accepts nothing
//   until its result is loaded; one write request per cycle.
// The block takes a new request while a result waits in the output
//   register; if the receiver still stalls when the next result is ready,
//   the block holds it and accepts nothing until out_ready.
// Reset (rst, synchronous) clears the match row, pattern_length and the
//   output valid. Pattern bytes are undefined until written.
`default_nettype none

module regex_dot_star_matcher
  import rdsm_pkg::*;
#(
  parameter int MAX_PATTERN = DEF_MAX_PATTERN
)(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [LENGTH_W-1:0] cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [CMD_W-1:0]    cmd,
  input  logic [INDEX_W-1:0]  pattern_index,
  input  logic [BYTE_W-1:0]   byte_value,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                matched
);

  rdsm_cmd_t    dp_cmd;
  rdsm_status_t dp_status;

  rdsm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dp_cmd    (dp_cmd),
    .dp_status (dp_status)
  );

  rdsm_datapath #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .cmd           (cmd),
    .pattern_index (pattern_index),
    .byte_value    (byte_value),
    .matched       (matched),
    .dp_cmd        (dp_cmd),
    .dp_status     (dp_status)
  );

endmodule

`default_nettype wire

// File: sv/rdsm_checker.sv
// Port-level checks for regex_dot_star_matcher, attached with a bind.
// Depends on rdsm_pkg for the request codes.
`default_nettype none

module rdsm_checker
  import rdsm_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic [CMD_W-1:0] cmd,
  input logic             out_valid,
  input logic             out_ready,
  input logic             matched
);

  // A held result keeps its value until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(matched))
    else $error("result changed while stalled");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  // A begin or text request occupies the block for the following cycles.
  a_busy_after_row: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (cmd == CMD_BEGIN || cmd == CMD_TEXT) |=> !in_ready)
    else $error("request accepted while the row is being rebuilt");

  // A write request leaves the input ready.
  a_write_one_cycle: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && cmd == CMD_WRITE |=> in_ready)
    else $error("pattern write stalled the input");

  // A new result only comes out of the busy period of a row request.
  a_result_from_row: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a row request");

endmodule

bind regex_dot_star_matcher rdsm_checker u_rdsm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .cmd       (cmd),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .matched   (matched)
);

`default_nettype wire

// File: verif/tb_regex_dot_star_matcher.sv
// Self-checking testbench for regex_dot_star_matcher: streams pattern writes, begin and
// text requests through randomized handshakes and checks every match bit against a
// local row predictor. Depends on rdsm_pkg and the matcher RTL.
`timescale 1ns / 1ps

module tb_regex_dot_star_matcher;
  import rdsm_pkg::*;

  localparam int MAXP          = DEF_MAX_PATTERN;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASES        = 9;
  localparam int PHASE_ITEMS   = 217;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]   op;
    logic [INDEX_W-1:0] idx;
    logic [BYTE_W-1:0]  data;
  } matcher_req_t;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                cfg_we    = 1'b0;
  logic [LENGTH_W-1:0] cfg_wdata = '0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  logic [CMD_W-1:0]    in_cmd    = '0;
  logic [INDEX_W-1:0]  in_index  = '0;
  logic [BYTE_W-1:0]   in_byte   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                matched;

  matcher_req_t pending_reqs[$];
  logic         expected_match[$];

  // Predictor state: pattern store, match row and pattern length.
  logic [BYTE_W-1:0]   pat_model [MAXP];
  logic [MAXP:0]       row_model    = '0;
  logic [LENGTH_W-1:0] length_model = '0;

  // Generator-side copy of the pattern, kept ahead of the predictor.
  logic [BYTE_W-1:0] gen_pat [MAXP];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches    = 0;
  int issued        = 0;
  int cycle_count   = 0;

  always #4 clk = ~clk;

  regex_dot_star_matcher #(.MAX_PATTERN(MAXP)) uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .cmd           (in_cmd),
    .pattern_index (in_index),
    .byte_value    (in_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .matched       (matched)
  );

  function automatic logic byte_hits(input logic [BYTE_W-1:0] p, input logic [BYTE_W-1:0] b);
    return (p == DOT_BYTE) || (p == b);
  endfunction

  // Applies one accepted request to the predictor and queues the match bit it yields.
  function automatic void advance_match_row(input logic [CMD_W-1:0] op,
                                            input logic [INDEX_W-1:0] idx,
                                            input logic [BYTE_W-1:0] b);
    logic [MAXP:0] nxt;
    int j;
    int used;
    nxt = '0;
    case (op)
      CMD_WRITE: begin
        pat_model[idx] = b;
      end
      CMD_BEGIN: begin
        nxt[0] = 1'b1;
        for (j = 1; j <= MAXP; j++) begin
          // A star with no element before it can never match.
          nxt[j] = (j >= 2 && pat_model[j-1] == STAR_BYTE) ? nxt[j-2] : 1'b0;
        end
      end
      CMD_TEXT: begin
        for (j = 1; j <= MAXP; j++) begin
          if (pat_model[j-1] == STAR_BYTE) begin
            if (j >= 2)
              nxt[j] = nxt[j-2] || (byte_hits(pat_model[j-2], b) && row_model[j]);
            else
              nxt[j] = 1'b0;
          end else begin
            nxt[j] = byte_hits(pat_model[j-1], b) && row_model[j-1];
          end
        end
      end
      default: ;
    endcase
    if (op == CMD_BEGIN || op == CMD_TEXT) begin
      row_model = nxt;
      used = (length_model > MAXP) ? MAXP : int'(length_model);
      expected_match.push_back(row_model[used]);
    end
  endfunction

  // Request driver.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_cmd   <= pending_reqs[0].op;
        in_index <= pending_reqs[0].idx;
        in_byte  <= pending_reqs[0].data;
        in_valid <= 1'b1;
        pending_reqs.delete(0);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready)
      advance_match_row(in_cmd, in_index, in_byte);
  end

  // Result monitor and receiver stalls.
  always @(posedge clk) begin : monitor
    logic want;
    if (!rst && out_valid && out_ready) begin
      if (expected_match.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: unexpected result, matched=%b", $realtime, matched);
        mismatches++;
      end else begin
        want = expected_match.pop_front();
        if (matched !== want) begin
          if (mismatches < 10)
            $display("%0t: matched expected %b, got %b", $realtime, want, matched);
          mismatches++;
        end
      end
    end
    out_ready <= rst ? 1'b0 : ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_regex_dot_star_matcher: done, errors");
      $finish;
    end
  end

  task automatic push_req(input logic [CMD_W-1:0] op, input logic [INDEX_W-1:0] idx,
                          input logic [BYTE_W-1:0] data);
    matcher_req_t r;
    r.op   = op;
    r.idx  = idx;
    r.data = data;
    pending_reqs.push_back(r);
    if (op == CMD_WRITE)
      gen_pat[idx] = data;
    if (op != CMD_UNUSED)
      issued++;
  endtask

  // Waits until no request is pending and every result has arrived, then lets
  // the block settle before returning.
  task automatic wait_quiet();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || in_valid || expected_match.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_length(input logic [LENGTH_W-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we       <= 1'b0;
    length_model  = v;
    @(negedge clk);
  endtask

  function automatic logic [BYTE_W-1:0] pick_pattern_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return 8'h61 + BYTE_W'($urandom_range(0, 2));
    if (r < 6) return DOT_BYTE;
    if (r < 8) return STAR_BYTE;
    return BYTE_W'($urandom);
  endfunction

  // One begin request followed by a text built to follow the active pattern,
  // sometimes with a stray byte at the end.
  task automatic add_sentence();
    int k;
    int n;
    int reps;
    int L;
    logic [BYTE_W-1:0] p;
    L = (length_model > MAXP) ? MAXP : int'(length_model);
    push_req(CMD_BEGIN, INDEX_W'($urandom), BYTE_W'($urandom));
    k = 0;
    while (k < L) begin
      p = gen_pat[k];
      if (k + 1 < L && gen_pat[k+1] == STAR_BYTE) begin
        reps = $urandom_range(0, 3);
        k += 2;
      end else begin
        reps = 1;
        k += 1;
      end
      for (n = 0; n < reps; n++)
        push_req(CMD_TEXT, INDEX_W'($urandom), (p == DOT_BYTE) ? BYTE_W'($urandom) : p);
    end
    if ($urandom_range(0, 99) < 15)
      push_req(CMD_TEXT, INDEX_W'($urandom), BYTE_W'($urandom));
  endtask

  task automatic run_random(input int count);
    int start;
    int r;
    int i;
    start = issued;
    while (issued - start < count) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        for (i = 0; i < MAXP; i++)
          push_req(CMD_WRITE, INDEX_W'(i), pick_pattern_byte());
      end else if (r < 18) begin
        // A lone write may land in the middle of a text.
        push_req(CMD_WRITE, INDEX_W'($urandom), BYTE_W'($urandom));
      end else if (r < 22) begin
        push_req(CMD_UNUSED, INDEX_W'($urandom), BYTE_W'($urandom));
      end else if (r < 30) begin
        for (i = 0; i < int'($urandom_range(1, 4)); i++)
          push_req(CMD_TEXT, INDEX_W'($urandom), BYTE_W'($urandom));
      end else begin
        add_sentence();
      end
    end
  endtask

  initial begin
    logic [BYTE_W-1:0] seed_pat [MAXP];
    int lengths [PHASES];
    int ph;
    int i;
    seed_pat = '{STAR_BYTE, 8'h61, STAR_BYTE, STAR_BYTE, DOT_BYTE, STAR_BYTE, 8'hFF, 8'h00,
                 8'h62, STAR_BYTE, DOT_BYTE, DOT_BYTE, STAR_BYTE, STAR_BYTE, 8'h63, 8'hFF};
    lengths  = '{0, 16, 31, 3, 7, 1, 12, 16, 5};
    send_idle_pct = 28;
    recv_idle_pct = 86;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part: fill the whole store first so no unwritten entry is ever read.
    set_length(5'd8);
    for (i = 0; i < MAXP; i++)
      push_req(CMD_WRITE, INDEX_W'(i), seed_pat[i]);
    push_req(CMD_TEXT, 4'h0, 8'h61);       // text before any begin
    push_req(CMD_UNUSED, 4'hF, 8'hFF);
    push_req(CMD_BEGIN, 4'hF, 8'h00);
    push_req(CMD_TEXT, 4'h0, 8'h61);
    push_req(CMD_TEXT, 4'h5, STAR_BYTE);
    push_req(CMD_TEXT, 4'hA, 8'hFF);
    push_req(CMD_TEXT, 4'hF, 8'h00);
    push_req(CMD_TEXT, 4'h3, 8'h78);
    push_req(CMD_BEGIN, 4'h0, 8'hFF);

    for (ph = 0; ph < PHASES; ph++) begin
      wait_quiet();
      if (ph / 3 == 0) begin
        send_idle_pct = 28;
        recv_idle_pct = 86;
      end else if (ph / 3 == 1) begin
        send_idle_pct = 86;
        recv_idle_pct = 28;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      set_length(LENGTH_W'(lengths[ph]));
      run_random(PHASE_ITEMS);
    end

    wait_quiet();
    if (mismatches == 0)
      $display("tb_regex_dot_star_matcher: done, clean");
    else
      $display("tb_regex_dot_star_matcher: done, errors");
    $finish;
  end

endmodule

// File: files.f
sv/rdsm_pkg.sv
sv/rdsm_ctrl.sv
sv/rdsm_datapath.sv
sv/regex_dot_star_matcher.sv
sv/rdsm_checker.sv
verif/tb_regex_dot_star_matcher.sv
